// File: rtl/stic_pkg.sv
package stic_pkg;

   localparam int MAX_POINTS_DEF   = 64;
   localparam int CORDIC_STEPS_DEF = 16;

   localparam logic [0:0] CMD_BUILD = 1'b0;
   localparam logic [0:0] CMD_QUERY = 1'b1;

   localparam logic [1:0] CSR_START  = 2'd0;
   localparam logic [1:0] CSR_END    = 2'd1;
   localparam logic [1:0] CSR_POINTS = 2'd2;

   localparam logic [2:0] STATUS_BUILT   = 3'd0;
   localparam logic [2:0] STATUS_INTERP  = 3'd1;
   localparam logic [2:0] STATUS_OUTSIDE = 3'd2;
   localparam logic [2:0] STATUS_NOSEG   = 3'd3;
   localparam logic [2:0] STATUS_INVALID = 3'd4;

   localparam logic [1:0] CMP_EQUAL  = 2'd0;
   localparam logic [1:0] CMP_EXACT  = 2'd1;
   localparam logic [1:0] CMP_INTERP = 2'd2;

   typedef struct packed {
      logic signed [15:0] sine;
      logic signed [31:0] absc;
   } entry_type;

   function automatic logic [31:0] atan_turn(input logic [4:0] i);
      logic [31:0] r;
      case (i)
         5'd0:  r = 32'd536870912;
         5'd1:  r = 32'd316933406;
         5'd2:  r = 32'd167458907;
         5'd3:  r = 32'd85004756;
         5'd4:  r = 32'd42667331;
         5'd5:  r = 32'd21354465;
         5'd6:  r = 32'd10679838;
         5'd7:  r = 32'd5340245;
         5'd8:  r = 32'd2670163;
         5'd9:  r = 32'd1335087;
         5'd10: r = 32'd667544;
         5'd11: r = 32'd333772;
         5'd12: r = 32'd166886;
         5'd13: r = 32'd83443;
         5'd14: r = 32'd41722;
         5'd15: r = 32'd20861;
         5'd16: r = 32'd10430;
         5'd17: r = 32'd5215;
         5'd18: r = 32'd2608;
         5'd19: r = 32'd1304;
         5'd20: r = 32'd652;
         5'd21: r = 32'd326;
         5'd22: r = 32'd163;
         5'd23: r = 32'd81;
         5'd24: r = 32'd41;
         5'd25: r = 32'd20;
         5'd26: r = 32'd10;
         5'd27: r = 32'd5;
         5'd28: r = 32'd3;
         5'd29: r = 32'd1;
         5'd30: r = 32'd1;
         default: r = 32'd0;
      endcase
      return r;
   endfunction

endpackage

// File: rtl/stic_ram.sv
module stic_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/stic_divider.sv
module stic_divider #(
   parameter int NW = 48,
   parameter int DW = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] dividend,
   input  logic [DW-1:0] divisor,
   output logic          done,
   output logic [NW-1:0] quotient
);

   localparam int CW = $clog2(NW + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [DW:0]   rem_ff, rem_in;
   logic [NW-1:0] quo_ff, quo_in;
   logic [DW-1:0] den_ff, den_in;
   logic [DW:0]   rem_shift;

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      den_in    = den_ff;
      rem_shift = {rem_ff[DW-1:0], quo_ff[NW-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         den_in  = divisor;
      end else if (busy_ff) begin
         if (rem_shift >= {1'b0, den_ff}) begin
            rem_in = rem_shift - {1'b0, den_ff};
            quo_in = {quo_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = rem_shift;
            quo_in = {quo_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(NW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: rtl/stic_cordic.sv
module stic_cordic
#(
   parameter int CORDIC_STEPS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [31:0] angle_x,
   output logic               done,
   output logic signed [15:0] sine
);

   import stic_pkg::*;

   localparam int SW = $clog2(CORDIC_STEPS + 1);

   localparam logic [2:0] C_IDLE = 3'd0;
   localparam logic [2:0] C_MUL  = 3'd1;
   localparam logic [2:0] C_INIT = 3'd2;
   localparam logic [2:0] C_ITER = 3'd3;
   localparam logic [2:0] C_FIN  = 3'd4;

   localparam logic [31:0]        K_LO = 32'd10430;
   localparam logic signed [31:0] K_HI = 32'sd1625002897;
   localparam logic signed [33:0] GAIN = 34'sd652032874;

   logic [2:0]         state_ff, state_in;
   logic               done_ff, done_in;
   logic signed [31:0] x_ff, x_in;
   logic [31:0]        lo_ff, lo_in;
   logic [31:0]        hi_ff, hi_in;
   logic [1:0]         quad_ff, quad_in;
   logic signed [33:0] cx_ff, cx_in;
   logic signed [33:0] cy_ff, cy_in;
   logic signed [32:0] z_ff, z_in;
   logic [SW-1:0]      cnt_ff, cnt_in;
   logic signed [15:0] y_ff, y_in;

   logic [31:0]        lo_prod;
   logic signed [63:0] hi_prod;
   logic [31:0]        phase;
   logic signed [33:0] dx, dy, sel, v;
   logic signed [32:0] ang;
   logic signed [15:0] v16;

   assign lo_prod = x_ff * K_LO;
   assign hi_prod = x_ff * K_HI;
   assign phase   = lo_ff + hi_ff;
   assign dx      = cy_ff >>> cnt_ff;
   assign dy      = cx_ff >>> cnt_ff;
   assign ang     = $signed({1'b0, atan_turn(5'(cnt_ff))});
   assign sel     = quad_ff[0] ? cx_ff : cy_ff;
   assign v       = (sel + 34'sd32768) >>> 16;

   always_comb begin
      if (v > 34'sd16384) begin
         v16 = 16'sd16384;
      end else if (v < -34'sd16384) begin
         v16 = -16'sd16384;
      end else begin
         v16 = v[15:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      done_in  = 1'b0;
      x_in     = x_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      quad_in  = quad_ff;
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      z_in     = z_ff;
      cnt_in   = cnt_ff;
      y_in     = y_ff;
      unique case (state_ff)
         C_IDLE: begin
            if (start) begin
               x_in     = angle_x;
               state_in = C_MUL;
            end
         end
         C_MUL: begin
            lo_in    = lo_prod;
            hi_in    = hi_prod[63:32];
            state_in = C_INIT;
         end
         C_INIT: begin
            quad_in  = phase[31:30];
            z_in     = $signed({3'b000, phase[29:0]});
            cx_in    = GAIN;
            cy_in    = '0;
            cnt_in   = '0;
            state_in = C_ITER;
         end
         C_ITER: begin
            if (z_ff >= 0) begin
               cx_in = cx_ff - dx;
               cy_in = cy_ff + dy;
               z_in  = z_ff - ang;
            end else begin
               cx_in = cx_ff + dx;
               cy_in = cy_ff - dy;
               z_in  = z_ff + ang;
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == SW'(CORDIC_STEPS - 1)) begin
               state_in = C_FIN;
            end
         end
         C_FIN: begin
            y_in     = quad_ff[1] ? -v16 : v16;
            done_in  = 1'b1;
            state_in = C_IDLE;
         end
         default: state_in = C_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      x_ff    <= x_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      quad_ff <= quad_in;
      cx_ff   <= cx_in;
      cy_ff   <= cy_in;
      z_ff    <= z_in;
      cnt_ff  <= cnt_in;
      y_ff    <= y_in;
   end

   assign done = done_ff;
   assign sine = y_ff;

endmodule

// File: rtl/sine_table_interpolate_compare.sv
// a build runs the step division (skipped for a single point), then one cordic sine per point
// a query scans the stored points, then runs the multiply and interpolation division
//   and then the cordic sine
// one item at a time; the next item is taken while the last result waits
// reset is synchronous and active high; it empties the table and restores the settings registers
module sine_table_interpolate_compare #(
   parameter int MAX_POINTS   = stic_pkg::MAX_POINTS_DEF,
   parameter int CORDIC_STEPS = stic_pkg::CORDIC_STEPS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // query_x
   input  logic [0:0]  req_tuser,   // command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // interpolated_value, exact_value, comparison, table_size
   output logic [2:0]  rsp_tuser,   // status
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   import stic_pkg::*;

   localparam int AW = $clog2(MAX_POINTS);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_HDIV   = 4'd1;
   localparam logic [3:0] S_BSIN   = 4'd2;
   localparam logic [3:0] S_BWAIT  = 4'd3;
   localparam logic [3:0] S_SCAN   = 4'd4;
   localparam logic [3:0] S_SREAD  = 4'd5;
   localparam logic [3:0] S_MUL    = 4'd6;
   localparam logic [3:0] S_DSTART = 4'd7;
   localparam logic [3:0] S_IDIV   = 4'd8;
   localparam logic [3:0] S_EXACT  = 4'd9;
   localparam logic [3:0] S_DONE   = 4'd10;

   logic signed [31:0] start_ff, end_ff;
   logic [6:0]         points_ff;

   logic [3:0]         state_ff, state_in;
   logic [6:0]         k_ff, k_in;
   logic [6:0]         n_ff, n_in;
   logic [6:0]         count_ff, count_in;
   logic [31:0]        h_ff, h_in;
   logic [31:0]        xacc_ff, xacc_in;
   logic signed [31:0] qx_ff, qx_in;
   entry_type          e1_ff, e1_in, e2_ff, e2_in;
   logic               neg_ff, neg_in;
   logic [47:0]        prod_ff, prod_in;
   logic [31:0]        den_ff, den_in;
   logic signed [15:0] interp_ff, interp_in;
   logic signed [15:0] exact_ff, exact_in;
   logic [2:0]         status_ff, status_in;
   logic [1:0]         cmp_ff, cmp_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [47:0]        rsp_data_ff, rsp_data_in;
   logic [2:0]         rsp_user_ff, rsp_user_in;

   logic        div_start, div_done;
   logic [47:0] div_num, div_q;
   logic [31:0] div_den;
   logic        cordic_start, cordic_done;
   logic signed [31:0] cordic_x;
   logic signed [15:0] cordic_y;
   logic        ram_we, ram_rd;
   entry_type   ram_wdata, ram_rdata;

   logic [6:0]         n_eff;
   logic signed [16:0] dy;
   logic [16:0]        mag;
   logic [31:0]        dxn;
   logic [15:0]        q16;

   assign n_eff = (32'(points_ff) > MAX_POINTS) ? 7'(MAX_POINTS) : points_ff;
   assign dy    = 17'(e1_ff.sine) - 17'(e2_ff.sine);
   assign mag   = dy[16] ? 17'(-dy) : 17'(dy);
   assign dxn   = qx_ff - e2_ff.absc;
   assign q16   = div_q[15:0];

   assign div_num  = (state_ff == S_IDLE) ? {16'd0, 32'(end_ff - start_ff)} : prod_ff;
   assign div_den  = (state_ff == S_IDLE) ? 32'(n_eff - 7'd1) : den_ff;
   assign cordic_x = (state_ff == S_BSIN) ? xacc_ff : qx_ff;
   assign ram_wdata.sine = cordic_y;
   assign ram_wdata.absc = xacc_ff;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      n_in         = n_ff;
      count_in     = count_ff;
      h_in         = h_ff;
      xacc_in      = xacc_ff;
      qx_in        = qx_ff;
      e1_in        = e1_ff;
      e2_in        = e2_ff;
      neg_in       = neg_ff;
      prod_in      = prod_ff;
      den_in       = den_ff;
      interp_in    = interp_ff;
      exact_in     = exact_ff;
      status_in    = status_ff;
      cmp_in       = cmp_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      div_start    = 1'b0;
      cordic_start = 1'b0;
      ram_we       = 1'b0;
      ram_rd       = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               qx_in     = req_tdata;
               interp_in = '0;
               exact_in  = '0;
               cmp_in    = CMP_EQUAL;
               if (req_tuser == CMD_BUILD) begin
                  if (!(start_ff < end_ff) || points_ff == 7'd0) begin
                     status_in = STATUS_INVALID;
                     state_in  = S_DONE;
                  end else begin
                     n_in    = n_eff;
                     k_in    = '0;
                     xacc_in = start_ff;
                     h_in    = '0;
                     if (n_eff == 7'd1) begin
                        state_in = S_BSIN;
                     end else begin
                        div_start = 1'b1;
                        state_in  = S_HDIV;
                     end
                  end
               end else if (!(start_ff < $signed(req_tdata) && $signed(req_tdata) < end_ff)) begin
                  status_in = STATUS_OUTSIDE;
                  state_in  = S_DONE;
               end else begin
                  k_in     = '0;
                  state_in = S_SCAN;
               end
            end
         end
         S_HDIV: begin
            if (div_done) begin
               h_in     = div_q[31:0];
               state_in = S_BSIN;
            end
         end
         S_BSIN: begin
            cordic_start = 1'b1;
            state_in     = S_BWAIT;
         end
         S_BWAIT: begin
            if (cordic_done) begin
               ram_we  = 1'b1;
               k_in    = k_ff + 7'd1;
               xacc_in = xacc_ff + h_ff;
               if (k_ff + 7'd1 == n_ff) begin
                  count_in  = n_ff;
                  status_in = STATUS_BUILT;
                  state_in  = S_DONE;
               end else begin
                  state_in = S_BSIN;
               end
            end
         end
         S_SCAN: begin
            if (k_ff >= count_ff) begin
               status_in = STATUS_NOSEG;
               state_in  = S_DONE;
            end else begin
               ram_rd   = 1'b1;
               state_in = S_SREAD;
            end
         end
         S_SREAD: begin
            if (k_ff >= 7'd2 && e2_ff.absc < qx_ff && qx_ff < ram_rdata.absc) begin
               e1_in    = ram_rdata;
               state_in = S_MUL;
            end else begin
               e2_in    = e1_ff;
               e1_in    = ram_rdata;
               k_in     = k_ff + 7'd1;
               state_in = S_SCAN;
            end
         end
         S_MUL: begin
            neg_in   = dy[16];
            prod_in  = mag[15:0] * dxn;
            den_in   = e1_ff.absc - e2_ff.absc;
            state_in = S_DSTART;
         end
         S_DSTART: begin
            div_start = 1'b1;
            state_in  = S_IDIV;
         end
         S_IDIV: begin
            if (div_done) begin
               interp_in    = neg_ff ? e2_ff.sine - $signed(q16) : e2_ff.sine + $signed(q16);
               cordic_start = 1'b1;
               state_in     = S_EXACT;
            end
         end
         S_EXACT: begin
            if (cordic_done) begin
               exact_in  = cordic_y;
               status_in = STATUS_INTERP;
               if (cordic_y > interp_ff) begin
                  cmp_in = CMP_EXACT;
               end else if (interp_ff > cordic_y) begin
                  cmp_in = CMP_INTERP;
               end else begin
                  cmp_in = CMP_EQUAL;
               end
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = status_ff;
               rsp_data_in  = {7'd0, count_ff, cmp_ff, exact_ff, interp_ff};
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff  <= '0;
         end_ff    <= 32'sd65536;
         points_ff <= 7'd1;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_START:  start_ff  <= csr_data;
            CSR_END:    end_ff    <= csr_data;
            CSR_POINTS: points_ff <= csr_data[6:0];
            default:    ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      k_ff        <= k_in;
      n_ff        <= n_in;
      h_ff        <= h_in;
      xacc_ff     <= xacc_in;
      qx_ff       <= qx_in;
      e1_ff       <= e1_in;
      e2_ff       <= e2_in;
      neg_ff      <= neg_in;
      prod_ff     <= prod_in;
      den_ff      <= den_in;
      interp_ff   <= interp_in;
      exact_ff    <= exact_in;
      status_ff   <= status_in;
      cmp_ff      <= cmp_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   stic_ram #(
      .WIDTH($bits(entry_type)),
      .DEPTH(MAX_POINTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (AW'(k_ff)),
      .wr_data (ram_wdata),
      .rd_en   (ram_rd),
      .rd_addr (AW'(k_ff)),
      .rd_data (ram_rdata)
   );

   stic_divider #(
      .NW(48),
      .DW(32)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_q)
   );

   stic_cordic #(
      .CORDIC_STEPS(CORDIC_STEPS)
   ) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cordic_start),
      .angle_x (cordic_x),
      .done    (cordic_done),
      .sine    (cordic_y)
   );

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= MAX_POINTS)
      else $error("stored count above table depth");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second item taken while busy");

   a_unused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != STATUS_INTERP |-> rsp_tdata[33:0] == 34'd0)
      else $error("result fields set without interpolation");

   a_cordic_done_state: assert property (@(posedge clock) disable iff (reset)
      cordic_done |-> state_ff == S_BWAIT || state_ff == S_EXACT)
      else $error("sine finished outside a waiting state");

   a_ram_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(ram_we && ram_rd))
      else $error("table read and write in one cycle");
`endif

endmodule
